[design/rps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rps_pkg;

  localparam int MAX_POSITIONS    = 65536;
  localparam int MAX_HEAD_DIM     = 256;
  localparam int ANGLE_ITERATIONS = 16;
  localparam int FRAC_BITS        = 24;

  localparam int POS_W   = 16;
  localparam int PAIR_W  = 7;
  localparam int HD_W    = 9;
  localparam int BASE_W  = 29;
  localparam int YARN_W  = 28;
  localparam int CFG_W   = 29;
  localparam int VAL_W   = 16;

  // 2*pair*base; for in-range pair indices the quotient stays below 2^BASE_W
  localparam int NUM_W   = PAIR_W + 1 + BASE_W;
  localparam int QUO_W   = BASE_W;
  localparam int REM_W   = HD_W;
  localparam int EXP_W   = QUO_W + 1;
  localparam int SHIFT_W = EXP_W - FRAC_BITS;
  localparam int MANT_W  = 33;
  localparam int INV_W   = 49;
  localparam int INV_SHIFT_MAX = 48;
  localparam int PROD_W  = 64;
  localparam int CORD_W  = 34;
  localparam int Q14_ONE = 16384;

  localparam logic [31:0] INV_TWO_PI = 32'd683565276;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [HD_W-1:0]   HEAD_DIM_RESET  = 9'd128;
  localparam logic [BASE_W-1:0] LOG2_BASE_RESET = 29'd222930853;
  localparam logic [YARN_W-1:0] LOG2_YARN_RESET = 28'd0;

  typedef enum logic [1:0] {
    REG_HEAD_DIM  = 2'd0,
    REG_LOG2_BASE = 2'd1,
    REG_LOG2_YARN = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              err;
    logic [POS_W-1:0]  pos;
    logic [NUM_W-1:0]  num;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r   = '0;
    b   = 64'd1 << 62;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // shift-subtract division, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // 2^(-2^-k) in Q0.32
  function automatic logic [31:0] exp_coef(input int k);
    logic [63:0] c;
    c = isqrt64(64'h8000_0000_0000_0000);
    for (int i = 2; i <= k; i++) c = isqrt64({c[31:0], 32'h0});
    return c[31:0];
  endfunction

  // atan(2^-k) in Q0.32 turns
  function automatic logic [31:0] atan_coef(input int k);
    logic signed [63:0] rad;
    logic [63:0] term;
    logic [63:0] scaled;
    int ex;
    rad = '0;
    if (k == 0) return 32'h2000_0000;
    for (int m = 0; m < 32; m++) begin
      ex = 62 - (2 * m + 1) * k;
      if (ex >= 0) begin
        term = udiv64(64'd1 << ex, 64'(2 * m + 1));
        if (m % 2 == 1) rad = rad - $signed(term);
        else rad = rad + $signed(term);
      end
    end
    scaled = (64'(rad) >> 30) * 64'(INV_TWO_PI) + 64'h8000_0000;
    return scaled[63:32];
  endfunction

  // inverse rotator gain in Q2.30
  function automatic logic [31:0] cordic_start();
    logic [63:0] cs;
    logic [63:0] s;
    cs = 64'd1 << 30;
    for (int k = 0; k < ANGLE_ITERATIONS; k++) begin
      s  = isqrt64((64'd1 << 60) + (64'd1 << (60 - 2 * k)));
      cs = udiv64(cs << 30, s);
    end
    return cs[31:0];
  endfunction

endpackage
`default_nettype wire

[design/rps_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module rps_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rps_pkg::POS_W-1:0]      in_position,
  input  logic [rps_pkg::PAIR_W-1:0]     in_pair_index,
  input  logic [rps_pkg::HD_W-1:0]       hd_eff,
  input  logic [rps_pkg::BASE_W-1:0]     log2_base,
  input  rps_pkg::queue_stat_t           q_stat,
  output logic                           push,
  output rps_pkg::item_t                 push_item
);

  localparam int NW = rps_pkg::NUM_W;
  localparam int HW = rps_pkg::HD_W;

  logic           fv_r;
  rps_pkg::item_t item_r;
  rps_pkg::item_t item_nxt;
  logic           take;

  assign push      = fv_r && !q_stat.full;
  assign in_ready  = !fv_r || push;
  assign take      = in_valid && in_ready;
  assign push_item = item_r;

  always_comb begin
    item_nxt.pos = in_position;
    item_nxt.num = NW'({in_pair_index, 1'b0}) * NW'(log2_base);
    item_nxt.err = (HW'(in_pair_index) >= (hd_eff >> 1)) ||
                   (32'(in_position) >= 32'(rps_pkg::MAX_POSITIONS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (take) begin
      fv_r <= 1'b1;
    end else if (push) begin
      fv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

endmodule
`default_nettype wire

[design/rps_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module rps_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rps_pkg::item_t       push_item,
  input  logic                 pop,
  output rps_pkg::item_t       head,
  output rps_pkg::queue_stat_t q_stat
);

  localparam int D  = rps_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(D);

  rps_pkg::item_t mem [0:D-1];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [PW:0]   cnt_r;

  assign q_stat.full  = (cnt_r == (PW+1)'(D));
  assign q_stat.empty = (cnt_r == '0);
  assign head         = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(D))
    else $error("queue count beyond depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.full && !pop) |=> $stable(cnt_r))
    else $error("queue count moved while full and not popped");

endmodule
`default_nettype wire

[design/rps_freq.sv]
`timescale 1ns / 1ps
`default_nettype none
module rps_freq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         pop,
  input  rps_pkg::item_t               head,
  input  logic [rps_pkg::HD_W-1:0]     hd_eff,
  input  logic [rps_pkg::YARN_W-1:0]   log2_yarn,
  output logic                         inv_vld,
  output logic                         inv_err,
  output logic [rps_pkg::POS_W-1:0]    inv_pos,
  output logic [rps_pkg::INV_W-1:0]    inv_val
);

  localparam int QW = rps_pkg::QUO_W;
  localparam int RW = rps_pkg::REM_W;
  localparam int NW = rps_pkg::NUM_W;
  localparam int EW = rps_pkg::EXP_W;
  localparam int FB = rps_pkg::FRAC_BITS;
  localparam int SW = rps_pkg::SHIFT_W;
  localparam int MW = rps_pkg::MANT_W;
  localparam int IW = rps_pkg::INV_W;

  typedef struct packed {
    logic                       err;
    logic [rps_pkg::POS_W-1:0]  pos;
    logic [RW-1:0]              rem;
    logic [QW-1:0]              work;
  } div_t;

  typedef struct packed {
    logic                       err;
    logic [rps_pkg::POS_W-1:0]  pos;
    logic [SW-1:0]              n;
    logic [FB-1:0]              f;
    logic [MW-1:0]              mant;
  } exs_t;

  logic dv_vld [0:QW];
  div_t dv     [0:QW];
  logic ex_vld [0:FB];
  exs_t ex     [0:FB];
  logic [EW-1:0] e_sum;

  // divider entry: remainder starts from the bits above the quotient range
  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld[0] <= 1'b0;
    else if (adv) dv_vld[0] <= pop;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].err  <= head.err;
      dv[0].pos  <= head.pos;
      dv[0].rem  <= RW'(head.num[NW-1:QW]);
      dv[0].work <= head.num[QW-1:0];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [RW:0] t;
    logic [RW:0] diff;
    logic        ge;
    assign t    = {dv[j].rem, dv[j].work[QW-1]};
    assign diff = t - {1'b0, hd_eff};
    assign ge   = t >= {1'b0, hd_eff};

    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld[j+1] <= 1'b0;
      else if (adv) dv_vld[j+1] <= dv_vld[j];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[j+1].err  <= dv[j].err;
        dv[j+1].pos  <= dv[j].pos;
        dv[j+1].rem  <= ge ? diff[RW-1:0] : t[RW-1:0];
        dv[j+1].work <= {dv[j].work[QW-2:0], ge};
      end
    end
  end

  assign e_sum = EW'(dv[QW].work) + EW'(log2_yarn);

  always_ff @(posedge clk) begin
    if (!rst_n) ex_vld[0] <= 1'b0;
    else if (adv) ex_vld[0] <= dv_vld[QW];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ex[0].err  <= dv[QW].err;
      ex[0].pos  <= dv[QW].pos;
      ex[0].n    <= e_sum[EW-1:FB];
      ex[0].f    <= e_sum[FB-1:0];
      ex[0].mant <= MW'(1) << (MW - 1);
    end
  end

  // one fraction bit of the exponent per stage, msb first
  for (genvar k = 1; k <= FB; k++) begin : g_exp
    localparam logic [31:0] COEF = rps_pkg::exp_coef(k);
    logic [MW+31:0] prod;
    assign prod = ex[k-1].mant * (MW+32)'(COEF);

    always_ff @(posedge clk) begin
      if (!rst_n) ex_vld[k] <= 1'b0;
      else if (adv) ex_vld[k] <= ex_vld[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ex[k].err  <= ex[k-1].err;
        ex[k].pos  <= ex[k-1].pos;
        ex[k].n    <= ex[k-1].n;
        ex[k].f    <= ex[k-1].f;
        ex[k].mant <= ex[k-1].f[FB-k] ? prod[MW+31:32] : ex[k-1].mant;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) inv_vld <= 1'b0;
    else if (adv) inv_vld <= ex_vld[FB];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inv_err <= ex[FB].err;
      inv_pos <= ex[FB].pos;
      inv_val <= (ex[FB].n > SW'(rps_pkg::INV_SHIFT_MAX)) ? '0 :
                 (IW'({ex[FB].mant, 16'h0}) >> ex[FB].n);
    end
  end

endmodule
`default_nettype wire

[design/rps_rotator.sv]
`timescale 1ns / 1ps
`default_nettype none
module rps_rotator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               inv_vld,
  input  logic                               inv_err,
  input  logic [rps_pkg::POS_W-1:0]          inv_pos,
  input  logic [rps_pkg::INV_W-1:0]          inv_val,
  output logic                               out_valid,
  output logic signed [rps_pkg::VAL_W-1:0]   out_cos_value,
  output logic signed [rps_pkg::VAL_W-1:0]   out_sin_value,
  output logic                               out_index_error
);

  localparam int CW = rps_pkg::CORD_W;
  localparam int NI = rps_pkg::ANGLE_ITERATIONS;
  localparam int PW = rps_pkg::PROD_W;
  localparam int VW = rps_pkg::VAL_W;
  localparam logic [31:0] X_START = rps_pkg::cordic_start();

  typedef struct packed {
    logic                  err;
    logic [1:0]            q;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic signed [CW-1:0]  z;
  } cor_t;

  logic          p_vld_r, ab_vld_r;
  logic          p_err_r, ab_err_r;
  logic [PW-1:0] p_r;
  logic [63:0]   a_r, b_r;
  logic [63:0]   lowsum;
  logic [31:0]   phase, phase_rnd, d;
  logic [1:0]    q;
  logic [PW:0]   p_full;

  logic cr_vld [0:NI];
  cor_t cr     [0:NI];

  logic signed [CW-1:0] oc, os;

  function automatic logic signed [VW-1:0] to_q14(input logic signed [CW-1:0] v);
    logic signed [CW:0]    s;
    logic signed [CW-16:0] r;
    s = {v[CW-1], v} + (CW+1)'(32768);
    r = s[CW:16];
    if (int'(r) > rps_pkg::Q14_ONE) return VW'(rps_pkg::Q14_ONE);
    if (int'(r) < -rps_pkg::Q14_ONE) return VW'(-rps_pkg::Q14_ONE);
    return r[VW-1:0];
  endfunction

  assign p_full = (PW+1)'(inv_pos) * (PW+1)'(inv_val);

  // angle in turns: position * invfreq / (2 pi), kept mod one turn
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r  <= 1'b0;
      ab_vld_r <= 1'b0;
    end else if (adv) begin
      p_vld_r  <= inv_vld;
      ab_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_err_r  <= inv_err;
      p_r      <= p_full[PW-1:0];
      ab_err_r <= p_err_r;
      a_r      <= p_r[63:32] * 64'(rps_pkg::INV_TWO_PI);
      b_r      <= p_r[31:0] * 64'(rps_pkg::INV_TWO_PI);
    end
  end

  // low partial product reaches bit 61, so the carry into the phase needs all 64 bits
  assign lowsum    = {16'h0, a_r[15:0], 32'h0} + b_r;
  assign phase     = a_r[47:16] + 32'(lowsum[63:48]);
  assign phase_rnd = phase + 32'h2000_0000;
  assign q         = phase_rnd[31:30];
  assign d         = phase - {q, 30'h0};

  always_ff @(posedge clk) begin
    if (!rst_n) cr_vld[0] <= 1'b0;
    else if (adv) cr_vld[0] <= ab_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cr[0].err <= ab_err_r;
      cr[0].q   <= q;
      cr[0].x   <= CW'(X_START);
      cr[0].y   <= '0;
      cr[0].z   <= {{(CW-32){d[31]}}, d};
    end
  end

  for (genvar k = 0; k < NI; k++) begin : g_cordic
    localparam logic [31:0] ATAN = rps_pkg::atan_coef(k);
    logic signed [CW-1:0] xs, ys;
    assign xs = cr[k].x >>> k;
    assign ys = cr[k].y >>> k;

    always_ff @(posedge clk) begin
      if (!rst_n) cr_vld[k+1] <= 1'b0;
      else if (adv) cr_vld[k+1] <= cr_vld[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cr[k+1].err <= cr[k].err;
        cr[k+1].q   <= cr[k].q;
        if (!cr[k].z[CW-1]) begin
          cr[k+1].x <= cr[k].x - ys;
          cr[k+1].y <= cr[k].y + xs;
          cr[k+1].z <= cr[k].z - CW'(ATAN);
        end else begin
          cr[k+1].x <= cr[k].x + ys;
          cr[k+1].y <= cr[k].y - xs;
          cr[k+1].z <= cr[k].z + CW'(ATAN);
        end
      end
    end
  end

  // quadrant fold back
  always_comb begin
    case (cr[NI].q)
      2'd0: begin oc = cr[NI].x;  os = cr[NI].y;  end
      2'd1: begin oc = -cr[NI].y; os = cr[NI].x;  end
      2'd2: begin oc = -cr[NI].x; os = -cr[NI].y; end
      default: begin oc = cr[NI].y; os = -cr[NI].x; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= cr_vld[NI];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_index_error <= cr[NI].err;
      out_cos_value   <= cr[NI].err ? '0 : to_q14(oc);
      out_sin_value   <= cr[NI].err ? '0 : to_q14(os);
    end
  end

endmodule
`default_nettype wire

[design/rotary_position_sincos.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake             payload
// in_       input      in_valid / in_ready   in_position, in_pair_index
// out_      output     out_valid / out_ready out_cos_value, out_sin_value, out_index_error
// cfg_      input      cfg_we                cfg_index, cfg_wdata
//
// one transfer per cycle in each direction when neither side stalls
// the data path runs through the front register, the queue, a 29-step divider pipeline, the exponent
//   add, 24 exponent multiply stages, phase stages and 16 rotation stages
// the back pipeline moves as a whole whenever the output register is empty or taken
// the 4-entry queue lets the front keep taking transfers while the back is held
// rst_n is synchronous; registers reset to head dimension 128, base 10000, no scaling
module rotary_position_sincos (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rps_pkg::POS_W-1:0]         in_position,
  input  logic [rps_pkg::PAIR_W-1:0]        in_pair_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rps_pkg::VAL_W-1:0]  out_cos_value,
  output logic signed [rps_pkg::VAL_W-1:0]  out_sin_value,
  output logic                              out_index_error,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [rps_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int HW = rps_pkg::HD_W;

  logic [HW-1:0]                 hdim_r;
  logic [rps_pkg::BASE_W-1:0]    log2_base_r;
  logic [rps_pkg::YARN_W-1:0]    log2_yarn_r;
  logic [HW-1:0]                 hd_eff;

  logic                  adv, q_pop, push;
  rps_pkg::item_t        push_item, head;
  rps_pkg::queue_stat_t  q_stat;

  logic                          inv_vld, inv_err;
  logic [rps_pkg::POS_W-1:0]     inv_pos;
  logic [rps_pkg::INV_W-1:0]     inv_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdim_r      <= rps_pkg::HEAD_DIM_RESET;
      log2_base_r <= rps_pkg::LOG2_BASE_RESET;
      log2_yarn_r <= rps_pkg::LOG2_YARN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rps_pkg::REG_HEAD_DIM:  hdim_r      <= cfg_wdata[HW-1:0];
        rps_pkg::REG_LOG2_BASE: log2_base_r <= cfg_wdata[rps_pkg::BASE_W-1:0];
        rps_pkg::REG_LOG2_YARN: log2_yarn_r <= cfg_wdata[rps_pkg::YARN_W-1:0];
        default: ;
      endcase
    end
  end

  assign hd_eff = (32'(hdim_r) > rps_pkg::MAX_HEAD_DIM) ?
                  HW'(rps_pkg::MAX_HEAD_DIM) : hdim_r;

  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && !q_stat.empty;

  rps_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_position  (in_position),
    .in_pair_index(in_pair_index),
    .hd_eff       (hd_eff),
    .log2_base    (log2_base_r),
    .q_stat       (q_stat),
    .push         (push),
    .push_item    (push_item)
  );

  rps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (q_pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  rps_freq u_freq (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .pop      (q_pop),
    .head     (head),
    .hd_eff   (hd_eff),
    .log2_yarn(log2_yarn_r),
    .inv_vld  (inv_vld),
    .inv_err  (inv_err),
    .inv_pos  (inv_pos),
    .inv_val  (inv_val)
  );

  rps_rotator u_rotator (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .inv_vld        (inv_vld),
    .inv_err        (inv_err),
    .inv_pos        (inv_pos),
    .inv_val        (inv_val),
    .out_valid      (out_valid),
    .out_cos_value  (out_cos_value),
    .out_sin_value  (out_sin_value),
    .out_index_error(out_index_error)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_index_error) |-> (out_cos_value == '0 && out_sin_value == '0))
    else $error("flagged entry with nonzero values");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_cos_value) <= rps_pkg::Q14_ONE &&
                   int'(out_cos_value) >= -rps_pkg::Q14_ONE &&
                   int'(out_sin_value) <= rps_pkg::Q14_ONE &&
                   int'(out_sin_value) >= -rps_pkg::Q14_ONE))
    else $error("output beyond unit range");
  a_hold_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !q_pop)
    else $error("queue popped while back pipeline held");

endmodule
`default_nettype wire

[bench/rotary_position_sincos_check.sv]
`timescale 1ns / 1ps
module rotary_position_sincos_check (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [rps_pkg::POS_W-1:0]         in_position,
  input  logic [rps_pkg::PAIR_W-1:0]        in_pair_index,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [rps_pkg::VAL_W-1:0]  out_cos_value,
  input  logic signed [rps_pkg::VAL_W-1:0]  out_sin_value,
  input  logic                              out_index_error,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [rps_pkg::CFG_W-1:0]         cfg_wdata,
  output int                                fails,
  output int                                pending
);
  import rps_pkg::*;

  typedef struct {
    logic signed [VAL_W-1:0] cos_v;
    logic signed [VAL_W-1:0] sin_v;
    logic                    err;
  } sincos_t;

  localparam longint unsigned TURN_PER_RAD = 64'd683565276;

  sincos_t             sincos_q[$];
  logic [HD_W-1:0]     hd_reg;
  logic [BASE_W-1:0]   base_reg;
  logic [YARN_W-1:0]   yarn_reg;
  longint unsigned     pow_coef [1:FRAC_BITS];
  longint              atan_turn [ANGLE_ITERATIONS];
  longint              gain_inv;

  assign pending = sincos_q.size();

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  initial begin
    longint rad;
    longint unsigned s;
    int ex;
    pow_coef[1] = sqrt_floor(64'd1 << 63);
    for (int k = 2; k <= FRAC_BITS; k++) pow_coef[k] = sqrt_floor(pow_coef[k-1] << 32);
    atan_turn[0] = 64'd1 << 29;
    for (int k = 1; k < ANGLE_ITERATIONS; k++) begin
      rad = 0;
      for (int m = 0; ; m++) begin
        ex = 62 - (2 * m + 1) * k;
        if (ex < 0) break;
        if (m % 2 == 1) rad = rad - longint'((64'd1 << ex) / (2 * m + 1));
        else rad = rad + longint'((64'd1 << ex) / (2 * m + 1));
      end
      atan_turn[k] = longint'(((longint'(unsigned'(rad)) >> 30) * TURN_PER_RAD
                               + (64'd1 << 31)) >> 32);
    end
    gain_inv = 64'd1 << 30;
    for (int k = 0; k < ANGLE_ITERATIONS; k++) begin
      s = sqrt_floor((64'd1 << 60) + (64'd1 << (60 - 2 * k)));
      gain_inv = longint'((unsigned'(gain_inv) << 30) / s);
    end
  end

  function automatic logic signed [VAL_W-1:0] round_q14(longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > Q14_ONE) r = Q14_ONE;
    if (r < -Q14_ONE) r = -Q14_ONE;
    return r[VAL_W-1:0];
  endfunction

  function automatic sincos_t rotate_entry(logic [POS_W-1:0] pos, logic [PAIR_W-1:0] pair);
    sincos_t res;
    longint unsigned hd, e, n, f, mant, inv, p, a, b, lowsum;
    logic [31:0] phase, q, d;
    longint x, y, z, xs, ys, oc, os;
    hd = (hd_reg > MAX_HEAD_DIM) ? MAX_HEAD_DIM : hd_reg;
    res.cos_v = 0;
    res.sin_v = 0;
    res.err = 1'b1;
    if (pair >= (hd >> 1)) return res;
    e = (2 * 64'(pair) * base_reg) / hd + yarn_reg;
    n = e >> FRAC_BITS;
    f = e & ((64'd1 << FRAC_BITS) - 1);
    mant = 64'd1 << 32;
    for (int k = 1; k <= FRAC_BITS; k++)
      if (f[FRAC_BITS-k]) mant = (mant * pow_coef[k]) >> 32;
    inv = (n > 48) ? 0 : (mant << 16) >> n;
    p = 64'(pos) * inv;
    a = (p >> 32) * TURN_PER_RAD;
    b = (p & 64'hFFFF_FFFF) * TURN_PER_RAD;
    lowsum = ((a & 64'hFFFF) << 32) + b;
    phase = 32'((a >> 16) + (lowsum >> 48));
    q = ((phase + 32'h2000_0000) >> 30) & 32'd3;
    d = phase - (q << 30);
    z = longint'($signed(d));
    x = gain_inv;
    y = 0;
    for (int k = 0; k < ANGLE_ITERATIONS; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_turn[k];
      end else begin
        x = x + ys; y = y - xs; z = z + atan_turn[k];
      end
    end
    case (q)
      0: begin oc = x;  os = y;  end
      1: begin oc = -y; os = x;  end
      2: begin oc = -x; os = -y; end
      default: begin oc = y; os = -x; end
    endcase
    res.cos_v = round_q14(oc);
    res.sin_v = round_q14(os);
    res.err = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    sincos_t want;
    if (!rst_n) begin
      hd_reg   <= HEAD_DIM_RESET;
      base_reg <= LOG2_BASE_RESET;
      yarn_reg <= LOG2_YARN_RESET;
      sincos_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HEAD_DIM:  hd_reg   <= cfg_wdata[HD_W-1:0];
          REG_LOG2_BASE: base_reg <= cfg_wdata[BASE_W-1:0];
          REG_LOG2_YARN: yarn_reg <= cfg_wdata[YARN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        sincos_q.insert(sincos_q.size(), rotate_entry(in_position, in_pair_index));
      if (out_valid && out_ready) begin
        if (sincos_q.size() == 0) begin
          report_mismatch("result with nothing pending", out_cos_value, 0);
        end else begin
          want = sincos_q.pop_front();
          if (out_cos_value !== want.cos_v) report_mismatch("cos", out_cos_value, want.cos_v);
          if (out_sin_value !== want.sin_v) report_mismatch("sin", out_sin_value, want.sin_v);
          if (out_index_error !== want.err)
            report_mismatch("index_error", out_index_error, want.err);
        end
      end
    end
  end
endmodule

[bench/rotary_position_sincos_test.sv]
`timescale 1ns / 1ps
module rotary_position_sincos_test;
  import rps_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE = 120;
  localparam int NUM_CFG = 9;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, out_index_error;
  logic [POS_W-1:0] in_position;
  logic [PAIR_W-1:0] in_pair_index;
  logic signed [VAL_W-1:0] out_cos_value, out_sin_value;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  int fails, pending;
  int tx_idle_pct, rx_idle_pct;
  int stall_cycles, results_seen, hold_left;
  bit hold_done;

  logic [HD_W-1:0]   hd_set   [NUM_CFG] = '{128, 2, 256, 511, 0, 1, 7, 256, 64};
  logic [BASE_W-1:0] base_set [NUM_CFG] = '{222930853, 335544320, 0, 222930853, 100,
                                            5, 335544320, 335544320, 222930853};
  logic [YARN_W-1:0] yarn_set [NUM_CFG] = '{0, 134217728, 0, 134217728, 5,
                                            0, 1, 0, 16777216};

  rotary_position_sincos dut (.*);

  rotary_position_sincos_check checker_i (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // receiver, with one long hold-off so the pipeline backs up into the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      results_seen <= 0;
      hold_left <= 0;
      hold_done <= 0;
    end else begin
      if (out_valid && out_ready) results_seen <= results_seen + 1;
      if (!hold_done && results_seen == 150) begin
        hold_done <= 1;
        hold_left <= 300;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_entry(logic [POS_W-1:0] pos, logic [PAIR_W-1:0] pair);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_position <= pos;
    in_pair_index <= pair;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender pauses until every transfer has come back, then lets the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int sent, half;
    logic [PAIR_W-1:0] pair;
    in_valid = 0;
    in_position = 0;
    in_pair_index = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    tx_idle_pct = 37;
    rx_idle_pct = 63;
    rst_n = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed corners under reset settings
    send_entry(0, 0);
    send_entry(16'hFFFF, 0);
    send_entry(16'hFFFF, 63);
    send_entry(0, 63);
    send_entry(1, 64);
    send_entry(16'hFFFF, 127);
    send_entry(16'h8000, 32);
    send_entry(16'hAAAA, 7'h55);
    send_entry(16'h5555, 7'h2A);
    send_entry(12345, 1);
    drain();
    write_reg(REG_UNUSED, '1);
    send_entry(16'hFFFF, 1);
    send_entry(100, 63);

    sent = 0;
    for (int c = 0; c < NUM_CFG; c++) begin
      drain();
      write_reg(REG_HEAD_DIM, hd_set[c]);
      write_reg(REG_LOG2_BASE, base_set[c]);
      write_reg(REG_LOG2_YARN, yarn_set[c]);
      half = ((hd_set[c] > MAX_HEAD_DIM) ? MAX_HEAD_DIM : hd_set[c]) / 2;
      if (half > 0) begin
        send_entry(16'hFFFF, PAIR_W'(half - 1));
        send_entry(0, PAIR_W'(half));
      end
      for (int i = 0; i < 117; i++) begin
        if (sent < 350) begin
          tx_idle_pct = 37; rx_idle_pct = 63;
        end else if (sent < 700) begin
          tx_idle_pct = 63; rx_idle_pct = 37;
        end else begin
          tx_idle_pct = 0; rx_idle_pct = 0;
        end
        if (half > 0 && $urandom_range(99) < 80) pair = PAIR_W'($urandom_range(half - 1));
        else pair = PAIR_W'($urandom_range(127));
        send_entry(POS_W'($urandom), pair);
        sent++;
      end
    end
    drain();
    if (fails == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
